### rtl/tcce_pkg.sv
`default_nettype none
package tcce_pkg;

    localparam int MAX_COLUMNS = 256;
    localparam int MAX_ROWS    = 128;
    localparam int TAB_WIDTH   = 8;

    localparam int COL_W  = 8;
    localparam int ROW_W  = 7;
    localparam int TAB_W  = $clog2(TAB_WIDTH);
    localparam int CFG_DW = 32;

    localparam logic [7:0] CH_BACKSPACE = 8'd8;
    localparam logic [7:0] CH_TAB       = 8'd9;
    localparam logic [7:0] CH_NEWLINE   = 8'd10;
    localparam logic [7:0] CH_SPACE     = 8'd32;

    localparam logic [COL_W:0] COLS_RESET = 9'd80;
    localparam logic [ROW_W:0] ROWS_RESET = 8'd25;

    typedef enum logic [1:0] {
        CFG_GRID_COLUMNS = 2'd0,
        CFG_GRID_ROWS    = 2'd1,
        CFG_FG_COLOR     = 2'd2,
        CFG_BG_COLOR     = 2'd3
    } t_cfg_idx;

    typedef enum logic {
        ST_IDLE,
        ST_TAB
    } t_state;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_GLYPH,
        OP_BS,
        OP_NL,
        OP_TAB_LOAD,
        OP_TAB_SPACE
    } t_op;

    typedef struct packed {
        logic in_is_nl;
        logic in_is_bs;
        logic in_is_tab;
        logic slot_free;
        logic tab_last;
    } t_dp_stat;

    typedef struct packed {
        t_op op;
    } t_dp_cmd;

    typedef struct packed {
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
    } t_cursor;

    // Column at or past the width goes to the next row; row past the end goes to 0.
    function automatic t_cursor f_wrap(input logic [COL_W:0] col, input logic [ROW_W:0] row,
                                       input logic [COL_W:0] cols, input logic [ROW_W:0] rows);
        t_cursor          res;
        logic [ROW_W:0]   r;
        r       = row;
        res.col = col[COL_W-1:0];
        if (col >= cols) begin
            res.col = '0;
            r       = row + 1'b1;
        end
        if (r >= rows) begin
            r = '0;
        end
        res.row = r[ROW_W-1:0];
        return res;
    endfunction

endpackage
`default_nettype wire

### rtl/text_console_cursor_engine_top.sv
`default_nettype none
// Text console cursor engine: takes character bytes and keeps a cursor on a
// grid_columns x grid_rows character grid, giving one cell-write word per
// drawn cell (column, row, glyph, last-of-run). A printable byte or a
// backspace gives one word; a newline gives none. A tab first loads its space
// count and then gives one space per cycle (one to eight), paced by the single
// output register. The output register lets a new byte in during the cycle its
// word is taken. Grid sizes of 0 read as 1 and sizes beyond 256 columns or 128
// rows saturate; colour registers are accepted but not used here. Write
// configuration only while idle.
module text_console_cursor_engine_top (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_cfg_we,
    input  wire  [1:0]                   i_cfg_index,
    input  wire  [tcce_pkg::CFG_DW-1:0]  i_cfg_wdata,
    input  wire                          i_in_valid,
    output logic                         o_in_ready,
    input  wire  [7:0]                   i_char_code,
    output logic                         o_out_valid,
    input  wire                          i_out_ready,
    output logic [tcce_pkg::COL_W-1:0]   o_cell_column,
    output logic [tcce_pkg::ROW_W-1:0]   o_cell_row,
    output logic [7:0]                   o_glyph_code,
    output logic                         o_last_of_run
);
    import tcce_pkg::*;

    t_dp_stat w_stat;
    t_dp_cmd  w_cmd;

    tcce_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    tcce_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_char_code   (i_char_code),
        .i_cmd         (w_cmd),
        .o_stat        (w_stat),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_cell_column (o_cell_column),
        .o_cell_row    (o_cell_row),
        .o_glyph_code  (o_glyph_code),
        .o_last_of_run (o_last_of_run)
    );

endmodule
`default_nettype wire

### rtl/tcce_ctrl.sv
`default_nettype none
module tcce_ctrl (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_in_valid,
    output logic                o_in_ready,
    input  tcce_pkg::t_dp_stat  i_stat,
    output tcce_pkg::t_dp_cmd   o_cmd
);
    import tcce_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid && i_stat.slot_free && i_stat.in_is_tab) begin
                    n_state = ST_TAB;
                end
            end
            ST_TAB: begin
                if (i_stat.slot_free && i_stat.tab_last) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready = 1'b0;
        o_cmd.op   = OP_NONE;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = i_stat.slot_free;
                if (i_in_valid && i_stat.slot_free) begin
                    if (i_stat.in_is_nl) begin
                        o_cmd.op = OP_NL;
                    end else if (i_stat.in_is_bs) begin
                        o_cmd.op = OP_BS;
                    end else if (i_stat.in_is_tab) begin
                        o_cmd.op = OP_TAB_LOAD;
                    end else begin
                        o_cmd.op = OP_GLYPH;
                    end
                end
            end
            ST_TAB: begin
                if (i_stat.slot_free) begin
                    o_cmd.op = OP_TAB_SPACE;
                end
            end
            default: o_cmd.op = OP_NONE;
        endcase
    end

endmodule
`default_nettype wire

### rtl/tcce_dp.sv
`default_nettype none
module tcce_dp (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_cfg_we,
    input  wire  [1:0]                       i_cfg_index,
    input  wire  [tcce_pkg::CFG_DW-1:0]      i_cfg_wdata,
    input  wire  [7:0]                       i_char_code,
    input  tcce_pkg::t_dp_cmd                i_cmd,
    output tcce_pkg::t_dp_stat               o_stat,
    output logic                             o_out_valid,
    input  wire                              i_out_ready,
    output logic [tcce_pkg::COL_W-1:0]       o_cell_column,
    output logic [tcce_pkg::ROW_W-1:0]       o_cell_row,
    output logic [7:0]                       o_glyph_code,
    output logic                             o_last_of_run
);
    import tcce_pkg::*;

    logic [COL_W:0]   r_grid_columns;
    logic [ROW_W:0]   r_grid_rows;
    logic [COL_W-1:0] r_col;
    logic [ROW_W-1:0] r_row;
    logic [TAB_W:0]   r_tab_cnt;
    logic             r_out_valid;
    logic [COL_W-1:0] r_out_col;
    logic [ROW_W-1:0] r_out_row;
    logic [7:0]       r_out_glyph;
    logic             r_out_last;

    logic [COL_W:0]   w_cols;
    logic [ROW_W:0]   w_rows;
    t_cursor          w_cur;
    t_cursor          w_adv;
    t_cursor          w_bs;
    t_cursor          w_nl;
    logic [TAB_W:0]   w_tab_count;
    logic             w_emit;

    // Configuration; colour words are accepted and dropped, as this block does not use them.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_columns <= COLS_RESET;
            r_grid_rows    <= ROWS_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_GRID_COLUMNS: r_grid_columns <= i_cfg_wdata[COL_W:0];
                CFG_GRID_ROWS:    r_grid_rows    <= i_cfg_wdata[ROW_W:0];
                CFG_FG_COLOR, CFG_BG_COLOR: ;
                default: ;
            endcase
        end
    end

    always_comb begin
        w_cols = r_grid_columns;
        if (r_grid_columns == '0) begin
            w_cols = (COL_W+1)'(1);
        end else if (r_grid_columns > (COL_W+1)'(MAX_COLUMNS)) begin
            w_cols = (COL_W+1)'(MAX_COLUMNS);
        end
        w_rows = r_grid_rows;
        if (r_grid_rows == '0) begin
            w_rows = (ROW_W+1)'(1);
        end else if (r_grid_rows > (ROW_W+1)'(MAX_ROWS)) begin
            w_rows = (ROW_W+1)'(MAX_ROWS);
        end
    end

    // Cursor may sit outside a grid that has just shrunk: wrap before use.
    always_comb begin
        w_cur = f_wrap({1'b0, r_col}, {1'b0, r_row}, w_cols, w_rows);
        w_adv = f_wrap({1'b0, w_cur.col} + 1'b1, {1'b0, w_cur.row}, w_cols, w_rows);
        w_nl  = f_wrap('0, {1'b0, w_cur.row} + 1'b1, w_cols, w_rows);
        w_bs  = w_cur;
        if (w_cur.col == '0) begin
            w_bs.col = COL_W'(w_cols - 1'b1);
            if (w_cur.row == '0) begin
                w_bs.row = ROW_W'(w_rows - 1'b1);
            end else begin
                w_bs.row = w_cur.row - 1'b1;
            end
        end else begin
            w_bs.col = w_cur.col - 1'b1;
        end
        w_tab_count = (TAB_W+1)'(TAB_WIDTH) - {1'b0, w_cur.col[TAB_W-1:0]};
    end

    assign w_emit = (i_cmd.op == OP_GLYPH) || (i_cmd.op == OP_BS) ||
                    (i_cmd.op == OP_TAB_SPACE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else begin
            case (i_cmd.op)
                OP_GLYPH, OP_TAB_SPACE: begin
                    r_col <= w_adv.col;
                    r_row <= w_adv.row;
                end
                OP_BS: begin
                    r_col <= w_bs.col;
                    r_row <= w_bs.row;
                end
                OP_NL: begin
                    r_col <= w_nl.col;
                    r_row <= w_nl.row;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_GLYPH: begin
                r_out_col   <= w_cur.col;
                r_out_row   <= w_cur.row;
                r_out_glyph <= i_char_code;
                r_out_last  <= 1'b1;
            end
            OP_BS: begin
                r_out_col   <= w_bs.col;
                r_out_row   <= w_bs.row;
                r_out_glyph <= CH_SPACE;
                r_out_last  <= 1'b1;
            end
            OP_TAB_LOAD: begin
                r_tab_cnt <= w_tab_count;
            end
            OP_TAB_SPACE: begin
                r_out_col   <= w_cur.col;
                r_out_row   <= w_cur.row;
                r_out_glyph <= CH_SPACE;
                r_out_last  <= (r_tab_cnt == (TAB_W+1)'(1));
                r_tab_cnt   <= r_tab_cnt - 1'b1;
            end
            default: ;
        endcase
    end

    always_comb begin
        o_stat.in_is_nl  = (i_char_code == CH_NEWLINE);
        o_stat.in_is_bs  = (i_char_code == CH_BACKSPACE);
        o_stat.in_is_tab = (i_char_code == CH_TAB);
        o_stat.slot_free = !r_out_valid || i_out_ready;
        o_stat.tab_last  = (r_tab_cnt == (TAB_W+1)'(1));
    end

    assign o_out_valid   = r_out_valid;
    assign o_cell_column = r_out_col;
    assign o_cell_row    = r_out_row;
    assign o_glyph_code  = r_out_glyph;
    assign o_last_of_run = r_out_last;

endmodule
`default_nettype wire

### rtl/tcce_chk.sv
`default_nettype none
module tcce_chk (
    input wire       i_clk,
    input wire       i_rst_n,
    input wire       i_in_valid,
    input wire       o_in_ready,
    input wire [7:0] i_char_code,
    input wire       o_out_valid,
    input wire       i_out_ready,
    input wire [7:0] o_cell_column,
    input wire [6:0] o_cell_row,
    input wire [7:0] o_glyph_code,
    input wire       o_last_of_run
);
    import tcce_pkg::*;

    logic w_acc;
    assign w_acc = i_in_valid && o_in_ready;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=>
            (o_out_valid && $stable(o_cell_column) && $stable(o_cell_row) &&
             $stable(o_glyph_code) && $stable(o_last_of_run)))
        else $error("stalled word changed");

    // a newline leaves no word behind
    a_newline: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && i_char_code == CH_NEWLINE) |=> !o_out_valid)
        else $error("newline produced a word");

    a_backspace: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && i_char_code == CH_BACKSPACE) |=>
            (o_out_valid && o_glyph_code == CH_SPACE && o_last_of_run))
        else $error("backspace word wrong");

    a_glyph: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && i_char_code != CH_BACKSPACE && i_char_code != CH_TAB &&
         i_char_code != CH_NEWLINE) |=>
            (o_out_valid && o_glyph_code == $past(i_char_code) && o_last_of_run))
        else $error("glyph word wrong");

endmodule

bind text_console_cursor_engine_top tcce_chk u_tcce_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in_valid),
    .o_in_ready    (o_in_ready),
    .i_char_code   (i_char_code),
    .o_out_valid   (o_out_valid),
    .i_out_ready   (i_out_ready),
    .o_cell_column (o_cell_column),
    .o_cell_row    (o_cell_row),
    .o_glyph_code  (o_glyph_code),
    .o_last_of_run (o_last_of_run)
);
`default_nettype wire
